// ===== src/sff_pkg.sv =====
// shared types, constants and the sm4 s-box for the sm4 ff1 decimal fpe block
// no dependencies; every other file imports this package
package sff_pkg;

  localparam int NUM_ROUNDS      = 10;
  localparam int MIN_DIGITS      = 6;
  localparam int MAX_DIGITS      = 18;
  localparam int MAX_TWEAK_BYTES = 16;
  localparam logic [7:0] RADIX_BYTE = 8'h0a;

  localparam int NUM_W  = 30;  // binary half value, below 10^9
  localparam int BCD_W  = 36;  // nine bcd digits
  localparam int HALF_DIGITS = 9;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_TWEAK = 2'd2,
    ST_BAD_DIGIT = 2'd3
  } status_t;

  typedef enum logic {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              kind;
    status_t           status;
    logic [3:0]        u;
    logic [3:0]        v;
    logic [4:0]        n;
    logic [NUM_W-1:0]  a;
    logic [NUM_W-1:0]  b;
    logic [127:0]      tweak;
    logic [4:0]        t;
  } job_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] rk;
  } key_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    sub_word = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

endpackage

// ===== src/sff_front.sv =====
// front end: takes requests, checks lengths and digits, turns bcd halves into binary
// depends on sff_pkg; feeds jobs into sff_queue
module sff_front
  import sff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [4:0]         in_digit_count,
  input  logic [BCD_W-1:0]   in_left_digits,
  input  logic [BCD_W-1:0]   in_right_digits,
  input  logic [63:0]        in_tweak_high,
  input  logic [63:0]        in_tweak_low,
  input  logic [4:0]         in_tweak_length,
  output logic               push_valid,
  output job_t               push_job,
  input  logic               push_ready
);

  typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} fstate_t;

  fstate_t          state_r;
  job_t             job_r;
  logic [BCD_W-1:0] lbcd_r;
  logic [BCD_W-1:0] rbcd_r;
  logic [3:0]       cnt_r;

  logic [3:0]       u_nxt;
  logic [4:0]       v_nxt;
  logic             bad_digit_nxt;
  status_t          status_nxt;
  logic [NUM_W-1:0] a_nxt;
  logic [NUM_W-1:0] b_nxt;

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_job   = job_r;

  always_comb begin
    u_nxt = in_digit_count[4:1];
    v_nxt = in_digit_count - {1'b0, u_nxt};
    bad_digit_nxt = 1'b0;
    for (int k = 0; k < HALF_DIGITS; k++) begin
      // only nibbles in use are checked
      if ((4'(k) < u_nxt) && (in_left_digits[4*k +: 4] > 4'd9)) bad_digit_nxt = 1'b1;
      if ((5'(k) < v_nxt) && (in_right_digits[4*k +: 4] > 4'd9)) bad_digit_nxt = 1'b1;
    end
    if ((in_digit_count < 5'(MIN_DIGITS)) || (in_digit_count > 5'(MAX_DIGITS))) begin
      status_nxt = ST_BAD_COUNT;
    end else if (in_tweak_length > 5'(MAX_TWEAK_BYTES)) begin
      status_nxt = ST_BAD_TWEAK;
    end else if (bad_digit_nxt) begin
      status_nxt = ST_BAD_DIGIT;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // one digit per half each cycle, top nibble first
  always_comb begin
    a_nxt = job_r.a;
    b_nxt = job_r.b;
    if (cnt_r < job_r.u) begin
      a_nxt = {job_r.a[NUM_W-4:0], 3'b000} + {job_r.a[NUM_W-2:0], 1'b0}
              + NUM_W'(lbcd_r[BCD_W-1 -: 4]);
    end
    if (cnt_r < job_r.v) begin
      b_nxt = {job_r.b[NUM_W-4:0], 3'b000} + {job_r.b[NUM_W-2:0], 1'b0}
              + NUM_W'(rbcd_r[BCD_W-1 -: 4]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            job_r.kind   <= in_kind;
            job_r.status <= status_nxt;
            job_r.u      <= u_nxt;
            job_r.v      <= v_nxt[3:0];
            job_r.n      <= in_digit_count;
            job_r.a      <= '0;
            job_r.b      <= '0;
            job_r.tweak  <= {in_tweak_high, in_tweak_low};
            job_r.t      <= in_tweak_length;
            lbcd_r       <= in_left_digits;
            rbcd_r       <= in_right_digits;
            cnt_r        <= 4'(HALF_DIGITS - 1);
            state_r      <= (status_nxt == ST_OK) ? F_CONV : F_PUSH;
          end
        end
        F_CONV: begin
          job_r.a <= a_nxt;
          job_r.b <= b_nxt;
          lbcd_r  <= {lbcd_r[BCD_W-5:0], 4'h0};
          rbcd_r  <= {rbcd_r[BCD_W-5:0], 4'h0};
          cnt_r   <= cnt_r - 4'd1;
          if (cnt_r == 4'd0) state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sff_queue.sv =====
// two-entry job queue between front end and cipher back end
// depends on sff_pkg for the job record
module sff_queue
  import sff_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  job_t push_job,
  output logic push_ready,
  output logic pop_valid,
  output job_t pop_job,
  input  logic pop_ready
);

  job_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== src/sff_keys.sv =====
// key registers and sm4 key schedule, one round key per cycle after reset or a key write
// depends on sff_pkg for the s-box and config codes
module sff_keys
  import sff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [4:0]  key_idx,
  output key_status_t key_st
);

  localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  logic [63:0]  key_high_r;
  logic [63:0]  key_low_r;
  logic [31:0]  k_r [4];
  logic [31:0]  rk_r [32];
  logic [4:0]   cnt_r;
  logic         busy_r;
  logic [31:0]  ck_nxt;
  logic [31:0]  t_nxt;
  logic [127:0] key_nxt;

  function automatic logic [7:0] ck_byte(input logic [4:0] i, input logic [1:0] j);
    logic [7:0] idx;
    idx = {1'b0, i, j};
    ck_byte = {idx[4:0], 3'b000} - idx;
  endfunction

  always_comb begin
    ck_nxt = {ck_byte(cnt_r, 2'd0), ck_byte(cnt_r, 2'd1),
              ck_byte(cnt_r, 2'd2), ck_byte(cnt_r, 2'd3)};
    t_nxt  = sub_word(k_r[1] ^ k_r[2] ^ k_r[3] ^ ck_nxt);
    t_nxt  = t_nxt ^ {t_nxt[18:0], t_nxt[31:19]} ^ {t_nxt[8:0], t_nxt[31:9]};
    key_nxt = {key_high_r, key_low_r};
    if (cfg_index == REG_KEY_HIGH) key_nxt[127:64] = cfg_data;
    else                           key_nxt[63:0]   = cfg_data;
  end

  assign key_st.busy = busy_r;
  assign key_st.rk   = rk_r[key_idx];

  always_ff @(posedge clk) begin
    if (busy_r) rk_r[cnt_r] <= k_r[0] ^ t_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      busy_r     <= 1'b1;
      cnt_r      <= '0;
      k_r[0] <= FK[127:96];
      k_r[1] <= FK[95:64];
      k_r[2] <= FK[63:32];
      k_r[3] <= FK[31:0];
    end else if (cfg_we) begin
      key_high_r <= key_nxt[127:64];
      key_low_r  <= key_nxt[63:0];
      busy_r     <= 1'b1;
      cnt_r      <= '0;
      k_r[0] <= key_nxt[127:96] ^ FK[127:96];
      k_r[1] <= key_nxt[95:64]  ^ FK[95:64];
      k_r[2] <= key_nxt[63:32]  ^ FK[63:32];
      k_r[3] <= key_nxt[31:0]   ^ FK[31:0];
    end else if (busy_r) begin
      k_r[0] <= k_r[1];
      k_r[1] <= k_r[2];
      k_r[2] <= k_r[3];
      k_r[3] <= k_r[0] ^ t_nxt;
      cnt_r  <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) busy_r <= 1'b0;
    end
  end

endmodule

// ===== src/sff_back.sv =====
// back end: sm4 round unit, cbc-mac per feistel round, bit-serial mod and bcd output
// depends on sff_pkg; takes jobs from sff_queue and round keys from sff_keys
module sff_back
  import sff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  job_t               pop_job,
  output logic               pop_ready,
  input  key_status_t        key_st,
  output logic [4:0]         key_idx,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [BCD_W-1:0]   out_left_result,
  output logic [BCD_W-1:0]   out_right_result
);

  typedef enum logic [2:0] {B_IDLE, B_LOAD, B_BLK, B_MOD, B_UPD, B_CONV, B_OUT} bstate_t;
  typedef enum logic [1:0] {PH_P, PH_Q1, PH_Q2} phase_t;

  bstate_t          state_r;
  phase_t           phase_r;
  job_t             job_r;
  logic [NUM_W-1:0] a_r;
  logic [NUM_W-1:0] b_r;
  logic [3:0]       rr_r;
  logic [127:0]     pb_r;
  logic [31:0]      x_r [4];
  logic [4:0]       sm_cnt_r;
  logic [63:0]      y_r;
  logic [NUM_W-1:0] rem_r;
  logic [4:0]       step_cnt_r;
  logic [NUM_W-1:0] la_r;
  logic [NUM_W-1:0] lb_r;
  logic [BCD_W-1:0] lbcd_r;
  logic [BCD_W-1:0] rbcd_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [BCD_W-1:0] out_left_r;
  logic [BCD_W-1:0] out_right_r;

  logic [31:0]      sm_t_nxt;
  logic [31:0]      x3_nxt;
  logic [127:0]     blk_nxt;
  logic [NUM_W-1:0] num_nxt;
  logic [NUM_W-1:0] md_nxt;
  logic [2:0]       bsz_nxt;
  logic             qlen32_nxt;
  logic [4:0]       rpos_nxt;
  logic [4:0]       qlast_nxt;
  logic [255:0]     q_nxt;
  logic [127:0]     p_blk;
  logic [NUM_W:0]   sum_nxt;
  logic [NUM_W-1:0] a_upd;
  logic [NUM_W-1:0] b_upd;
  logic             last_round;

  function automatic logic [NUM_W-1:0] pow10(input logic [3:0] d);
    case (d)
      4'd0:    pow10 = NUM_W'(1);
      4'd1:    pow10 = NUM_W'(10);
      4'd2:    pow10 = NUM_W'(100);
      4'd3:    pow10 = NUM_W'(1000);
      4'd4:    pow10 = NUM_W'(10000);
      4'd5:    pow10 = NUM_W'(100000);
      4'd6:    pow10 = NUM_W'(1000000);
      4'd7:    pow10 = NUM_W'(10000000);
      4'd8:    pow10 = NUM_W'(100000000);
      4'd9:    pow10 = NUM_W'(1000000000);
      default: pow10 = NUM_W'(1);
    endcase
  endfunction

  function automatic logic [2:0] num_bytes(input logic [3:0] d);
    case (d)
      4'd1, 4'd2:       num_bytes = 3'd1;
      4'd3, 4'd4:       num_bytes = 3'd2;
      4'd5, 4'd6, 4'd7: num_bytes = 3'd3;
      4'd8, 4'd9:       num_bytes = 3'd4;
      default:          num_bytes = 3'd0;
    endcase
  endfunction

  function automatic logic [NUM_W-1:0] mod_step(input logic [NUM_W-1:0] rem,
                                                input logic bitin,
                                                input logic [NUM_W-1:0] md);
    logic [NUM_W:0] r2;
    r2 = {rem, bitin};
    if (r2 >= {1'b0, md}) r2 = r2 - {1'b0, md};
    mod_step = r2[NUM_W-1:0];
  endfunction

  // shift-add-3 step of binary to bcd
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                               input logic bitin);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int k = 0; k < HALF_DIGITS; k++) begin
      if (adj[4*k +: 4] >= 4'd5) adj[4*k +: 4] = adj[4*k +: 4] + 4'd3;
    end
    dd_step = {adj[BCD_W-2:0], bitin};
  endfunction

  assign key_idx = sm_cnt_r;

  always_comb begin
    sm_t_nxt = sub_word(x_r[1] ^ x_r[2] ^ x_r[3] ^ key_st.rk);
    sm_t_nxt = sm_t_nxt ^ {sm_t_nxt[29:0], sm_t_nxt[31:30]} ^ {sm_t_nxt[21:0], sm_t_nxt[31:22]}
             ^ {sm_t_nxt[13:0], sm_t_nxt[31:14]} ^ {sm_t_nxt[7:0], sm_t_nxt[31:8]};
    x3_nxt  = x_r[0] ^ sm_t_nxt;
    blk_nxt = {x3_nxt, x_r[3], x_r[2], x_r[1]};
  end

  // q = tweak, zero pad, round byte, num(b) big endian (num(a) for decrypt); one or two blocks
  always_comb begin
    num_nxt    = job_r.kind ? a_r : b_r;
    md_nxt     = pow10(rr_r[0] ? job_r.v : job_r.u);
    bsz_nxt    = num_bytes(job_r.v);
    qlen32_nxt = ({1'b0, job_r.t} + 6'd1 + {3'b000, bsz_nxt}) >= 6'd16;
    qlast_nxt  = qlen32_nxt ? 5'd31 : 5'd15;
    rpos_nxt   = qlast_nxt - {2'b00, bsz_nxt};
    for (int i = 0; i < 32; i++) begin
      logic [4:0]  bi;
      logic [4:0]  k;
      logic [31:0] nw;
      bi = 5'(i);
      k  = qlast_nxt - bi;
      nw = {{(32-NUM_W){1'b0}}, num_nxt} >> {k[1:0], 3'b000};
      if ((i < 16) && (bi < job_r.t)) begin
        q_nxt[255-8*i -: 8] = job_r.tweak[127-8*(i%16) -: 8];
      end else if (bi == rpos_nxt) begin
        q_nxt[255-8*i -: 8] = {4'h0, rr_r};
      end else if ((bi > rpos_nxt) && (bi <= qlast_nxt)) begin
        q_nxt[255-8*i -: 8] = nw[7:0];
      end else begin
        q_nxt[255-8*i -: 8] = 8'h00;
      end
    end
  end

  assign p_blk = {8'h01, 8'h02, 8'h01, 8'h00, 8'h00, RADIX_BYTE, RADIX_BYTE, {4'h0, pop_job.u},
                  24'h0, {3'b000, pop_job.n}, 24'h0, {3'b000, pop_job.t}};

  always_comb begin
    if (!job_r.kind) begin
      sum_nxt = {1'b0, a_r} + {1'b0, rem_r};
      if (sum_nxt >= {1'b0, md_nxt}) sum_nxt = sum_nxt - {1'b0, md_nxt};
      a_upd = b_r;
      b_upd = sum_nxt[NUM_W-1:0];
      last_round = (rr_r == 4'(NUM_ROUNDS - 1));
    end else begin
      if (b_r >= rem_r) sum_nxt = {1'b0, b_r} - {1'b0, rem_r};
      else              sum_nxt = {1'b0, b_r} + {1'b0, md_nxt} - {1'b0, rem_r};
      a_upd = sum_nxt[NUM_W-1:0];
      b_upd = a_r;
      last_round = (rr_r == 4'd0);
    end
  end

  assign pop_ready        = (state_r == B_IDLE) && !key_st.busy;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_left_result  = out_left_r;
  assign out_right_result = out_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop_valid && !key_st.busy) begin
            job_r <= pop_job;
            a_r   <= pop_job.a;
            b_r   <= pop_job.b;
            rr_r  <= pop_job.kind ? 4'(NUM_ROUNDS - 1) : 4'd0;
            if (pop_job.status != ST_OK) begin
              la_r       <= '0;
              lb_r       <= '0;
              lbcd_r     <= '0;
              rbcd_r     <= '0;
              step_cnt_r <= '0;
              state_r    <= B_CONV;
            end else begin
              x_r[0]   <= p_blk[127:96];
              x_r[1]   <= p_blk[95:64];
              x_r[2]   <= p_blk[63:32];
              x_r[3]   <= p_blk[31:0];
              sm_cnt_r <= '0;
              phase_r  <= PH_P;
              state_r  <= B_BLK;
            end
          end
        end
        B_LOAD: begin
          x_r[0]   <= pb_r[127:96] ^ q_nxt[255:224];
          x_r[1]   <= pb_r[95:64]  ^ q_nxt[223:192];
          x_r[2]   <= pb_r[63:32]  ^ q_nxt[191:160];
          x_r[3]   <= pb_r[31:0]   ^ q_nxt[159:128];
          sm_cnt_r <= '0;
          phase_r  <= PH_Q1;
          state_r  <= B_BLK;
        end
        B_BLK: begin
          if (sm_cnt_r == 5'd31) begin
            case (phase_r)
              PH_P: begin
                pb_r    <= blk_nxt;
                state_r <= B_LOAD;
              end
              PH_Q1: begin
                if (qlen32_nxt) begin
                  x_r[0]   <= blk_nxt[127:96] ^ q_nxt[127:96];
                  x_r[1]   <= blk_nxt[95:64]  ^ q_nxt[95:64];
                  x_r[2]   <= blk_nxt[63:32]  ^ q_nxt[63:32];
                  x_r[3]   <= blk_nxt[31:0]   ^ q_nxt[31:0];
                  sm_cnt_r <= '0;
                  phase_r  <= PH_Q2;
                end else begin
                  y_r        <= blk_nxt[127:64];
                  rem_r      <= '0;
                  step_cnt_r <= '0;
                  state_r    <= B_MOD;
                end
              end
              default: begin
                y_r        <= blk_nxt[127:64];
                rem_r      <= '0;
                step_cnt_r <= '0;
                state_r    <= B_MOD;
              end
            endcase
          end else begin
            x_r[0]   <= x_r[1];
            x_r[1]   <= x_r[2];
            x_r[2]   <= x_r[3];
            x_r[3]   <= x3_nxt;
            sm_cnt_r <= sm_cnt_r + 5'd1;
          end
        end
        B_MOD: begin
          // two quotient bits per cycle
          rem_r      <= mod_step(mod_step(rem_r, y_r[63], md_nxt), y_r[62], md_nxt);
          y_r        <= {y_r[61:0], 2'b00};
          step_cnt_r <= step_cnt_r + 5'd1;
          if (step_cnt_r == 5'd31) state_r <= B_UPD;
        end
        B_UPD: begin
          a_r  <= a_upd;
          b_r  <= b_upd;
          rr_r <= job_r.kind ? rr_r - 4'd1 : rr_r + 4'd1;
          if (last_round) begin
            la_r       <= a_upd;
            lb_r       <= b_upd;
            lbcd_r     <= '0;
            rbcd_r     <= '0;
            step_cnt_r <= '0;
            state_r    <= B_CONV;
          end else begin
            state_r <= B_LOAD;
          end
        end
        B_CONV: begin
          lbcd_r     <= dd_step(lbcd_r, la_r[NUM_W-1]);
          rbcd_r     <= dd_step(rbcd_r, lb_r[NUM_W-1]);
          la_r       <= {la_r[NUM_W-2:0], 1'b0};
          lb_r       <= {lb_r[NUM_W-2:0], 1'b0};
          step_cnt_r <= step_cnt_r + 5'd1;
          if (step_cnt_r == 5'(NUM_W - 1)) state_r <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= job_r.status;
            out_left_r   <= lbcd_r;
            out_right_r  <= rbcd_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sm4_ff1_decimal_fpe.sv =====
// top level of the sm4 ff1 decimal format-preserving cipher
// depends on sff_pkg, sff_front, sff_queue, sff_keys and sff_back
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_ready   kind, digit count, bcd halves, tweak
//   out_      result     out_valid / out_ready status, bcd result halves
//   cfg_      write      cfg_we                key_high (index 0), key_low (index 1)
//
// the front end accepts a request, converts its nine bcd digits and pushes it to the
// queue; the back end encrypts the p block, then per round loads q, runs one or two
// cipher blocks, reduces mod and updates, then converts to bcd and outputs, paced by
// the single sm4 round unit and the 2-bit mod loop; an error request goes straight to
// conversion. after reset and after each key write the key schedule runs; requests wait
// in the queue meanwhile. the 2-entry queue and output register decouple stalls
module sm4_ff1_decimal_fpe
  import sff_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [4:0]         in_digit_count,
  input  logic [BCD_W-1:0]   in_left_digits,
  input  logic [BCD_W-1:0]   in_right_digits,
  input  logic [63:0]        in_tweak_high,
  input  logic [63:0]        in_tweak_low,
  input  logic [4:0]         in_tweak_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [BCD_W-1:0]   out_left_result,
  output logic [BCD_W-1:0]   out_right_result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data
);

  logic        push_valid;
  job_t        push_job;
  logic        push_ready;
  logic        pop_valid;
  job_t        pop_job;
  logic        pop_ready;
  key_status_t key_st;
  logic [4:0]  key_idx;

  sff_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_digit_count,
    .in_left_digits, .in_right_digits, .in_tweak_high, .in_tweak_low,
    .in_tweak_length, .push_valid, .push_job, .push_ready
  );

  sff_queue u_queue (
    .clk, .rst_n, .push_valid, .push_job, .push_ready,
    .pop_valid, .pop_job, .pop_ready
  );

  sff_keys u_keys (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .key_idx, .key_st
  );

  sff_back u_back (
    .clk, .rst_n, .pop_valid, .pop_job, .pop_ready, .key_st, .key_idx,
    .out_valid, .out_ready, .out_status, .out_left_result, .out_right_result
  );

endmodule

// ===== src/sff_checker.sv =====
// port-level checks on the result channel of the top level, bound in below
// depends on sff_pkg for status codes
module sff_checker
  import sff_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [BCD_W-1:0]   out_left_result,
  input logic [BCD_W-1:0]   out_right_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_left_result) && $stable(out_right_result))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_left_result == '0) && (out_right_result == '0))
    else $error("error result carries digits");

  a_ok_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> (out_left_result[3:0] <= 4'd9)
      && (out_right_result[3:0] <= 4'd9) && (out_left_result[35:32] <= 4'd9)
      && (out_right_result[35:32] <= 4'd9))
    else $error("non-digit nibble in result");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sm4_ff1_decimal_fpe sff_checker u_sff_checker (.*);

// ===== sim/tb_top.sv =====
// testbench for sm4_ff1_decimal_fpe: random and directed ff1 requests checked
// against an in-bench sm4/ff1 predictor; depends on sff_pkg and the rtl in src
module tb_top;
  import sff_pkg::*;

  typedef struct {
    logic        kind;
    logic [4:0]  n;
    logic [35:0] left;
    logic [35:0] right;
    logic [63:0] tw_hi;
    logic [63:0] tw_lo;
    logic [4:0]  t;
  } fpe_req_t;

  typedef struct {
    status_t     st;
    logic [35:0] left;
    logic [35:0] right;
  } fpe_res_t;

  localparam int WATCHDOG_LIMIT = 30000;
  localparam int LONG_HOLD = 5000;
  localparam int BSZ_BY_DIGITS [10] = '{0, 1, 1, 2, 2, 3, 3, 3, 4, 4};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [4:0] in_digit_count = '0;
  logic [35:0] in_left_digits = '0;
  logic [35:0] in_right_digits = '0;
  logic [63:0] in_tweak_high = '0;
  logic [63:0] in_tweak_low = '0;
  logic [4:0] in_tweak_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [35:0] out_left_result;
  logic [35:0] out_right_result;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  fpe_req_t pending_reqs[$];
  fpe_res_t expected_res[$];
  logic [31:0] sched_keys [32];
  logic [63:0] key_hi, key_lo;

  logic in_fire = 1'b0;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_by_status [4] = '{0, 0, 0, 0};
  int n_decrypt = 0;

  sm4_ff1_decimal_fpe u_dut (.*);

  always #4 clk = ~clk;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic void load_key_schedule();
    logic [31:0] k0, k1, k2, k3, ck, s, nk;
    k0 = key_hi[63:32] ^ 32'ha3b1bac6;
    k1 = key_hi[31:0] ^ 32'h56aa3350;
    k2 = key_lo[63:32] ^ 32'h677d9197;
    k3 = key_lo[31:0] ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31 - 8 * j -: 8] = 8'(((4 * i + j) * 7) & 255);
      s = sbox_word(k1 ^ k2 ^ k3 ^ ck);
      nk = k0 ^ s ^ rotl32(s, 13) ^ rotl32(s, 23);
      sched_keys[i] = nk;
      k0 = k1; k1 = k2; k2 = k3; k3 = nk;
    end
  endfunction

  function automatic logic [127:0] blk_cipher(input logic [127:0] blk);
    logic [31:0] x0, x1, x2, x3, s, nx;
    {x0, x1, x2, x3} = blk;
    for (int i = 0; i < 32; i++) begin
      s = sbox_word(x1 ^ x2 ^ x3 ^ sched_keys[i]);
      nx = x0 ^ s ^ rotl32(s, 2) ^ rotl32(s, 10) ^ rotl32(s, 18) ^ rotl32(s, 24);
      x0 = x1; x1 = x2; x2 = x3; x3 = nx;
    end
    return {x3, x2, x1, x0};
  endfunction

  // cbc-mac of the encrypted p block chained over q, top 8 bytes
  function automatic logic [63:0] round_mac(input logic [127:0] p_enc,
      input logic [127:0] tweak, input int t, input int bsz, input int rnd,
      input logic [63:0] num);
    logic [7:0] q [64];
    logic [127:0] blk, qb;
    int pad, qlen, base;
    pad = 16 - (t + 1 + bsz) % 16;
    qlen = t + pad + 1 + bsz;
    for (int i = 0; i < 64; i++) q[i] = 8'h00;
    for (int i = 0; i < t; i++) q[i] = tweak[127 - 8 * i -: 8];
    q[t + pad] = 8'(rnd);
    base = t + pad + 1;
    for (int i = 0; i < bsz; i++) q[base + bsz - 1 - i] = num[8 * i +: 8];
    blk = p_enc;
    for (int off = 0; off < qlen; off += 16) begin
      for (int i = 0; i < 16; i++) qb[127 - 8 * i -: 8] = q[off + i];
      blk = blk_cipher(blk ^ qb);
    end
    return blk[127:64];
  endfunction

  function automatic logic bcd_value(input logic [35:0] bcd, input int cnt,
      output logic [63:0] val);
    val = 0;
    for (int k = cnt; k > 0; k--) begin
      if (bcd[4 * (k - 1) +: 4] > 4'd9) return 1'b0;
      val = val * 10 + bcd[4 * (k - 1) +: 4];
    end
    return 1'b1;
  endfunction

  function automatic logic [35:0] value_bcd(input logic [63:0] val, input int cnt);
    logic [35:0] r;
    r = '0;
    for (int k = 0; k < cnt; k++) begin
      r[4 * k +: 4] = 4'(val % 10);
      val = val / 10;
    end
    return r;
  endfunction

  function automatic fpe_res_t ff1_predict(input fpe_req_t rq);
    fpe_res_t res;
    int u, v, bsz;
    logic [63:0] a, b, c, y, ym, md;
    logic [127:0] p_enc, tweak;
    logic ok_a, ok_b;
    res.st = ST_OK; res.left = '0; res.right = '0;
    if (rq.n < MIN_DIGITS || rq.n > MAX_DIGITS) begin
      res.st = ST_BAD_COUNT;
      return res;
    end
    if (rq.t > MAX_TWEAK_BYTES) begin
      res.st = ST_BAD_TWEAK;
      return res;
    end
    u = rq.n / 2;
    v = rq.n - u;
    ok_a = bcd_value(rq.left, u, a);
    ok_b = bcd_value(rq.right, v, b);
    if (!ok_a || !ok_b) begin
      res.st = ST_BAD_DIGIT;
      return res;
    end
    tweak = {rq.tw_hi, rq.tw_lo};
    p_enc = blk_cipher({8'h01, 8'h02, 8'h01, 8'h00, 8'h00, RADIX_BYTE, RADIX_BYTE,
                        8'(u), 24'h0, 3'b0, rq.n, 24'h0, 3'b0, rq.t});
    bsz = BSZ_BY_DIGITS[v];
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      int r;
      r = rq.kind ? NUM_ROUNDS - 1 - i : i;
      md = 1;
      repeat ((r % 2) ? v : u) md = md * 10;
      if (!rq.kind) begin
        y = round_mac(p_enc, tweak, rq.t, bsz, r, b);
        c = (a + y % md) % md;
        a = b;
        b = c;
      end else begin
        c = b;
        b = a;
        y = round_mac(p_enc, tweak, rq.t, bsz, r, b);
        ym = y % md;
        a = (c >= ym) ? c - ym : c + md - ym;
      end
    end
    res.left = value_bcd(a, u);
    res.right = value_bcd(b, v);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
      input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", n_got, what, got, want);
    errors++;
  endtask

  // accept tracking, prediction, checking and watchdog
  always @(posedge clk) begin
    fpe_req_t rq;
    fpe_res_t want;
    in_fire <= in_valid && in_ready;
    if (in_valid && in_ready) begin
      rq.kind = in_kind; rq.n = in_digit_count;
      rq.left = in_left_digits; rq.right = in_right_digits;
      rq.tw_hi = in_tweak_high; rq.tw_lo = in_tweak_low; rq.t = in_tweak_length;
      want = ff1_predict(rq);
      expected_res.push_back(want);
      n_by_status[want.st]++;
      if (rq.kind) n_decrypt++;
      n_sent++;
    end
    if (out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result status", 64'(out_status), 64'(0));
      end else begin
        want = expected_res.pop_front();
        if (out_status !== want.st)
          report_mismatch("status", 64'(out_status), 64'(want.st));
        if (out_left_result !== want.left)
          report_mismatch("left", 64'(out_left_result), 64'(want.left));
        if (out_right_result !== want.right)
          report_mismatch("right", 64'(out_right_result), 64'(want.right));
      end
      n_got++;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else if (rst_n) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 80);
  endfunction

  // request driver
  always @(negedge clk) begin
    fpe_req_t rq;
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        in_kind <= rq.kind; in_digit_count <= rq.n;
        in_left_digits <= rq.left; in_right_digits <= rq.right;
        in_tweak_high <= rq.tw_hi; in_tweak_low <= rq.tw_lo;
        in_tweak_length <= rq.t;
        in_valid <= 1'b1;
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
    end
  end

  function automatic fpe_req_t make_req(input logic kind, input int n,
      input logic [63:0] val_l, input logic [63:0] val_r, input int t);
    fpe_req_t rq;
    int u;
    u = n / 2;
    rq.kind = kind; rq.n = 5'(n); rq.t = 5'(t);
    rq.tw_hi = {$urandom, $urandom}; rq.tw_lo = {$urandom, $urandom};
    // junk above the digits in use
    rq.left = {$urandom, $urandom};
    rq.right = {$urandom, $urandom};
    if (n >= 2 && n <= 18) begin
      for (int k = 0; k < u; k++) rq.left[4 * k +: 4] = 4'(val_l % 10 ** (k + 1) / 10 ** k);
      for (int k = 0; k < n - u; k++)
        rq.right[4 * k +: 4] = 4'(val_r % 10 ** (k + 1) / 10 ** k);
    end
    return rq;
  endfunction

  function automatic fpe_req_t random_req();
    fpe_req_t rq;
    int n, sel;
    n = $urandom_range(MIN_DIGITS, MAX_DIGITS);
    rq = make_req($urandom_range(0, 1), n, {$urandom, $urandom}, {$urandom, $urandom},
                  $urandom_range(0, MAX_TWEAK_BYTES));
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      rq.n = $urandom_range(0, 1) ? 5'($urandom_range(0, MIN_DIGITS - 1))
                                  : 5'($urandom_range(MAX_DIGITS + 1, 31));
      if ($urandom_range(0, 1)) rq.t = 5'($urandom_range(0, 31));
    end else if (sel == 1) begin
      rq.t = 5'($urandom_range(MAX_TWEAK_BYTES + 1, 31));
    end else if (sel == 2) begin
      if ($urandom_range(0, 1)) rq.left[4 * $urandom_range(0, n / 2 - 1) +: 4] =
                                  4'($urandom_range(10, 15));
      else rq.right[4 * $urandom_range(0, n - n / 2 - 1) +: 4] = 4'($urandom_range(10, 15));
    end
    return rq;
  endfunction

  task automatic write_key(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi = val;
    else key_lo = val;
    load_key_schedule();
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    fpe_req_t rq;
    key_hi = '0; key_lo = '0;
    load_key_schedule();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, both directions, alignment and error priority
    calm <= 1'b1;
    pending_reqs.push_back(make_req(0, 6, 0, 0, 0));
    pending_reqs.push_back(make_req(1, 6, 999, 999, 0));
    pending_reqs.push_back(make_req(0, 18, 999999999, 999999999, 16));
    pending_reqs.push_back(make_req(1, 18, 0, 0, 16));
    pending_reqs.push_back(make_req(0, 7, 123, 4567, 5));
    pending_reqs.push_back(make_req(1, 17, 12345678, 987654321, 9));
    // q aligned so the padding is a whole block
    pending_reqs.push_back(make_req(0, 6, 42, 42, 13));
    pending_reqs.push_back(make_req(1, 18, 7, 7, 11));
    pending_reqs.push_back(make_req(0, 5, 1, 1, 0));
    pending_reqs.push_back(make_req(0, 19, 1, 1, 0));
    pending_reqs.push_back(make_req(1, 0, 1, 1, 31));
    pending_reqs.push_back(make_req(0, 31, 1, 1, 31));
    pending_reqs.push_back(make_req(0, 10, 1, 1, 17));
    pending_reqs.push_back(make_req(1, 10, 1, 1, 31));
    rq = make_req(0, 8, 1234, 5678, 4);
    rq.left[3:0] = 4'hf;
    pending_reqs.push_back(rq);
    rq = make_req(1, 9, 1234, 56789, 4);
    rq.right[19:16] = 4'ha;
    pending_reqs.push_back(rq);
    // tweak fault wins over digit fault
    rq.t = 5'd20;
    pending_reqs.push_back(rq);
    // all unused nibbles set, never checked
    rq = make_req(0, 6, 5, 6, 3);
    rq.left[35:12] = '1; rq.right[35:12] = '1;
    pending_reqs.push_back(rq);
    rq.tw_hi = '1; rq.tw_lo = '1; rq.t = 5'd16;
    pending_reqs.push_back(rq);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_key(REG_KEY_HIGH, '1);
          write_key(REG_KEY_LOW, '1);
        end
        1: write_key(REG_KEY_LOW, '0);
        7: begin
          write_key(REG_KEY_HIGH, '0);
          write_key(REG_KEY_LOW, '0);
        end
        default: begin
          write_key(REG_KEY_HIGH, {$urandom, $urandom});
          write_key(REG_KEY_LOW, {$urandom, $urandom});
        end
      endcase
      calm <= (ph == 3);
      for (int i = 0; i < 104; i++) pending_reqs.push_back(random_req());
      if (ph == 2) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end
      drain();
    end

    $display("%0d requests, %0d decrypt; status ok/count/tweak/digit = %0d/%0d/%0d/%0d",
             n_sent, n_decrypt, n_by_status[0], n_by_status[1], n_by_status[2],
             n_by_status[3]);
    $display("%0d results checked over 9 key settings, %0d mismatches", n_got, errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
